// ===== design/rau_pkg.sv =====
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int RES_NUM_W = 64;
    localparam int RES_DEN_W = 63;
    localparam int MAG_W     = 64;

    // operation codes
    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_CMP = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture operands
        logic mul_lo;    // first product pair
        logic mul_hi;    // second product pair
        logic combine;   // form numerator/denominator magnitudes
        logic gcd_step;  // one Euclid remainder bit step
        logic gcd_swap;  // finish one remainder
        logic div_init;  // start exact divisions
        logic div_step;  // one quotient bit
        logic finish;    // write result register
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic err;
        logic is_cmp;
        logic y_zero;
        logic rem_done;
        logic div_done;
    } t_sts;

endpackage

// ===== design/rau_ctrl.sv =====
module rau_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_out_free,
    input  rau_pkg::t_sts i_sts,
    output rau_pkg::t_ctl o_ctl,
    output logic          o_busy
);
    import rau_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL0 = 8'b0000_0010,
        S_MUL1 = 8'b0000_0100,
        S_COMB = 8'b0000_1000,
        S_GCD  = 8'b0001_0000,
        S_DINI = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_MUL0;
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = (i_sts.err || i_sts.is_cmp) ? S_DONE : S_COMB;
            S_COMB: n_state = S_GCD;
            S_GCD:  if (i_sts.y_zero) n_state = S_DINI;
            S_DINI: n_state = S_DIV;
            S_DIV:  if (i_sts.div_done) n_state = S_DONE;
            S_DONE: if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // commands
    always_comb begin
        o_ctl          = '0;
        o_ctl.load     = (r_state == S_IDLE) && i_start;
        o_ctl.mul_lo   = (r_state == S_MUL0);
        o_ctl.mul_hi   = (r_state == S_MUL1);
        o_ctl.combine  = (r_state == S_COMB);
        o_ctl.gcd_step = (r_state == S_GCD) && !i_sts.y_zero && !i_sts.rem_done;
        o_ctl.gcd_swap = (r_state == S_GCD) && !i_sts.y_zero && i_sts.rem_done;
        o_ctl.div_init = (r_state == S_DINI);
        o_ctl.div_step = (r_state == S_DIV) && !i_sts.div_done;
        o_ctl.finish   = (r_state == S_DONE) && i_out_free;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== design/rau_dp.sv =====
module rau_dp #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic          i_clk,
    input  rau_pkg::t_ctl i_ctl,
    input  logic [2:0]    i_cmd,
    input  logic [31:0]   i_a_num,
    input  logic [30:0]   i_a_den,
    input  logic [31:0]   i_b_num,
    input  logic [30:0]   i_b_den,
    output rau_pkg::t_sts o_sts,
    output logic [63:0]   o_res_num,
    output logic [62:0]   o_res_den,
    output logic          o_is_less,
    output logic          o_is_equal,
    output logic          o_is_greater,
    output logic          o_status
);
    import rau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(MAG_W + 1);

    logic [2:0]        r_cmd;
    logic signed [W-1:0] r_an, r_bn;
    logic [W-2:0]      r_ad, r_bd;
    logic              r_err;
    logic signed [63:0] r_p0, r_p1, r_p2;  // an*bd (or an*bn), bn*ad, ad*bd
    logic              r_neg;
    logic [63:0]       r_mn, r_md;         // magnitudes to reduce
    logic [63:0]       r_x, r_y;           // Euclid pair
    logic [63:0]       r_rem;              // partial remainder of x mod y
    logic [CW-1:0]     r_bit;              // remainder / quotient bit count
    logic [63:0]       r_qn, r_qd, r_rn, r_rd;

    // operands, resized to the operand width
    logic signed [W-1:0] a_n, b_n;
    logic [W-2:0]        a_d, b_d;
    assign a_n = W'(i_a_num);
    assign b_n = W'(i_b_num);
    assign a_d = (W-1)'(i_a_den);
    assign b_d = (W-1)'(i_b_den);

    // operand selection, one 33x33 signed multiplier pair shared by the mul_lo and mul_hi steps
    logic signed [32:0] mx_a, mx_b, my_a, my_b;
    logic signed [63:0] m_x, m_y;
    logic signed [63:0] sum;
    always_comb begin
        mx_a = 33'(r_an);
        mx_b = 33'(signed'({1'b0, r_bd}));
        my_a = 33'(r_bn);
        my_b = 33'(signed'({1'b0, r_ad}));
        if (i_ctl.mul_hi) begin
            mx_a = 33'(signed'({1'b0, r_ad}));
            mx_b = 33'(signed'({1'b0, r_bd}));
            my_a = 33'(r_an);
            my_b = 33'(r_bn);
        end
        m_x = 64'(mx_a) * 64'(mx_b);
        m_y = 64'(my_a) * 64'(my_b);
        sum = (r_cmd == CMD_SUB) ? r_p0 - r_p1 : r_p0 + r_p1;
    end

    // one restoring remainder bit: shift in next dividend bit of r_x
    logic [64:0] rem_sh;
    logic [63:0] xbit;
    assign rem_sh = {r_rem, r_x[6'(r_bit - 1'b1)]};
    assign xbit   = 64'(0);

    // division step for both exact quotients by r_x (the gcd)
    logic [64:0] dn_sh, dd_sh;
    assign dn_sh = {r_rn, r_mn[6'(r_bit - 1'b1)]};
    assign dd_sh = {r_rd, r_md[6'(r_bit - 1'b1)]};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_an <= a_n; r_bn <= b_n; r_ad <= a_d; r_bd <= b_d;
            r_err <= (a_d == '0) || (b_d == '0) || (i_cmd > CMD_CMP) ||
                     ((i_cmd == CMD_DIV) && (b_n == '0));
        end
        if (i_ctl.mul_lo) begin
            r_p0 <= m_x;
            r_p1 <= m_y;
        end
        if (i_ctl.mul_hi) begin
            r_p2 <= m_x;
            if (r_cmd == CMD_MUL) r_p0 <= m_y;
        end
        if (i_ctl.combine) begin
            // numerator and denominator before reduction
            if (r_cmd == CMD_DIV) begin
                r_neg <= r_p0[63] ^ r_p1[63];
                r_mn  <= r_p0[63] ? -r_p0 : r_p0;
                r_md  <= r_p1[63] ? -r_p1 : r_p1;
                r_x   <= r_p0[63] ? -r_p0 : r_p0;
                r_y   <= r_p1[63] ? -r_p1 : r_p1;
            end else begin
                r_neg <= (r_cmd == CMD_MUL) ? r_p0[63] : sum[63];
                r_mn  <= (r_cmd == CMD_MUL) ? (r_p0[63] ? -r_p0 : r_p0)
                                             : (sum[63] ? -sum : sum);
                r_x   <= (r_cmd == CMD_MUL) ? (r_p0[63] ? -r_p0 : r_p0)
                                             : (sum[63] ? -sum : sum);
                r_md  <= r_p2;
                r_y   <= r_p2;
            end
            r_rem <= '0;
            r_bit <= CW'(MAG_W);
        end
        if (i_ctl.gcd_step) begin
            r_rem <= (rem_sh >= {1'b0, r_y}) ? 64'(rem_sh - {1'b0, r_y})
                                              : rem_sh[63:0];
            r_bit <= r_bit - 1'b1;
        end
        if (i_ctl.gcd_swap) begin
            r_x   <= r_y;
            r_y   <= r_rem;
            r_rem <= xbit;
            r_bit <= CW'(MAG_W);
        end
        if (i_ctl.div_init) begin
            r_qn <= '0; r_qd <= '0; r_rn <= '0; r_rd <= '0;
            r_bit <= CW'(MAG_W);
        end
        if (i_ctl.div_step) begin
            r_qn <= {r_qn[62:0], dn_sh >= {1'b0, r_x}};
            r_qd <= {r_qd[62:0], dd_sh >= {1'b0, r_x}};
            r_rn <= (dn_sh >= {1'b0, r_x}) ? 64'(dn_sh - {1'b0, r_x}) : dn_sh[63:0];
            r_rd <= (dd_sh >= {1'b0, r_x}) ? 64'(dd_sh - {1'b0, r_x}) : dd_sh[63:0];
            r_bit <= r_bit - 1'b1;
        end
        if (i_ctl.finish) begin
            o_res_num    <= '0;
            o_res_den    <= '0;
            o_is_less    <= 1'b0;
            o_is_equal   <= 1'b0;
            o_is_greater <= 1'b0;
            o_status     <= r_err;
            if (!r_err && r_cmd == CMD_CMP) begin
                o_res_den    <= 63'd1;
                o_is_less    <= r_p0 < r_p1;
                o_is_equal   <= r_p0 == r_p1;
                o_is_greater <= r_p0 > r_p1;
            end else if (!r_err) begin
                if (r_qn == '0) begin
                    o_res_den <= 63'd1;
                end else begin
                    o_res_num <= r_neg ? -r_qn : r_qn;
                    o_res_den <= r_qd[62:0];
                end
            end
        end
    end

    assign o_sts.err      = r_err;
    assign o_sts.is_cmp   = (r_cmd == CMD_CMP);
    assign o_sts.y_zero   = (r_y == '0);
    assign o_sts.rem_done = (r_bit == '0);
    assign o_sts.div_done = (r_bit == '0);

endmodule

// ===== design/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: add/sub/mul/div/compare of two fractions.
// Compare and error cases go from the products straight to the result; arithmetic
// runs bit-serial Euclid remainders and then the exact divisions before the result.
// Throughput: one item at a time, set by the bit-serial remainder unit.
// The result register frees the input as soon as the result is captured.
// Reset (i_rst_n low, synchronous) returns the controller to idle.
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[2:0], a_num[34:3], a_den[65:35], b_num[97:66], b_den[128:98]
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // res_num[63:0], res_den[126:64], is_less[127], is_equal[128],
    // is_greater[129], status[130]
    output logic [135:0] m_axis_tdata
);
    import rau_pkg::*;

    t_ctl ctl;
    t_sts sts;
    logic busy, r_valid;
    logic [63:0] res_num;
    logic [62:0] res_den;
    logic lt, eq, gt, st;

    assign s_axis_tready = !busy;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {5'd0, st, gt, eq, lt, res_den, res_num};

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)           r_valid <= 1'b0;
        else if (ctl.finish)    r_valid <= 1'b1;
        else if (m_axis_tready) r_valid <= 1'b0;
    end

    rau_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(s_axis_tvalid),
        .i_out_free(!r_valid || m_axis_tready),
        .i_sts(sts), .o_ctl(ctl), .o_busy(busy)
    );

    rau_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .i_clk(i_clk), .i_ctl(ctl),
        .i_cmd(s_axis_tdata[2:0]), .i_a_num(s_axis_tdata[34:3]),
        .i_a_den(s_axis_tdata[65:35]), .i_b_num(s_axis_tdata[97:66]),
        .i_b_den(s_axis_tdata[128:98]), .o_sts(sts),
        .o_res_num(res_num), .o_res_den(res_den),
        .o_is_less(lt), .o_is_equal(eq), .o_is_greater(gt), .o_status(st)
    );

endmodule

// ===== design/rau_checker.sv =====
module rau_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata
);
    // at most one relation flag per result
    a_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $countones(m_axis_tdata[129:127]) <= 1)
        else $error("several relation flags");
    // error results are all zero
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[130] |-> m_axis_tdata[126:0] == '0)
        else $error("error result not cleared");
    // good results have nonzero denominator
    a_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[130] |-> m_axis_tdata[126:64] != '0)
        else $error("zero denominator");
    // busy after a transfer in
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted twice");
endmodule

bind rational_arithmetic_unit rau_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// ===== tb/sv/tb_rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit;
    import rau_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int DRAIN_CYCLES   = 7000;
    localparam int LONG_HOLD      = 400;
    localparam logic [2:0] CMD_BAD_LO = 3'd5;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] a_num;
        logic [30:0] a_den;
        logic [31:0] b_num;
        logic [30:0] b_den;
    } t_operands;

    typedef struct {
        logic [63:0] num;
        logic [62:0] den;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        st;
    } t_fraction;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;

    t_operands pending_ops[$];
    t_fraction expected_fracs[$];
    t_operands cur_ops;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int hold_seen;
    int hold_left;
    int mismatches;
    int idle_cycles;
    int n_sent;
    int n_checked;
    int n_errors_seen;
    int n_cmp_seen;

    rational_arithmetic_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // magnitude of a signed 64-bit value
    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? -v : v;
    endfunction

    // normalize n/d: sign to numerator, divide out the gcd, zero as 0/1
    function automatic t_fraction reduce_frac(input logic signed [63:0] n,
                                              input logic signed [63:0] d);
        t_fraction   r;
        logic        neg;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] mn;
        logic [63:0] md;
        neg = n[63] ^ d[63];
        mn  = abs64(n);
        md  = abs64(d);
        x   = mn;
        y   = md;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        mn = mn / x;
        md = md / x;
        if (mn == 0) begin
            md  = 64'd1;
            neg = 1'b0;
        end
        r     = '{default: '0};
        r.num = neg ? -mn : mn;
        r.den = md[62:0];
        return r;
    endfunction

    // expected result for one operand set
    function automatic t_fraction predict_frac(input t_operands op);
        t_fraction          r;
        logic signed [63:0] an;
        logic signed [63:0] bn;
        logic signed [63:0] ad;
        logic signed [63:0] bd;
        logic signed [63:0] lhs;
        logic signed [63:0] rhs;
        an = {{32{op.a_num[31]}}, op.a_num};
        bn = {{32{op.b_num[31]}}, op.b_num};
        ad = {33'd0, op.a_den};
        bd = {33'd0, op.b_den};
        r  = '{default: '0};
        if (ad == 0 || bd == 0 || op.cmd > CMD_CMP || (op.cmd == CMD_DIV && bn == 0)) begin
            r.st = 1'b1;
            return r;
        end
        lhs = an * bd;
        rhs = bn * ad;
        case (op.cmd)
            CMD_ADD: r = reduce_frac(lhs + rhs, ad * bd);
            CMD_SUB: r = reduce_frac(lhs - rhs, ad * bd);
            CMD_MUL: r = reduce_frac(an * bn, ad * bd);
            CMD_DIV: r = reduce_frac(lhs, ad * bn);
            default: begin
                r.den = 63'd1;
                r.lt  = lhs < rhs;
                r.eq  = lhs == rhs;
                r.gt  = lhs > rhs;
            end
        endcase
        return r;
    endfunction

    // random numerator: mostly small, sometimes full width
    function automatic logic [31:0] rand_num();
        case ($urandom_range(3, 0))
            0: return $urandom_range(20, 0);
            1: return -$urandom_range(20, 0);
            2: return $urandom_range(2000, 0) - 1000;
            default: return $urandom;
        endcase
    endfunction

    // random denominator, zero now and then
    function automatic logic [30:0] rand_den();
        logic [31:0] v;
        if ($urandom_range(99, 0) < 2)
            return 31'd0;
        case ($urandom_range(2, 0))
            0: v = $urandom_range(24, 1);
            1: v = $urandom_range(5000, 1);
            default: v = $urandom;
        endcase
        if (v[30:0] == 0)
            v = 32'd1;
        return v[30:0];
    endfunction

    task automatic add_op(input logic [2:0] c, input logic [31:0] an, input logic [30:0] ad,
                          input logic [31:0] bn, input logic [30:0] bd);
        t_operands op;
        op = '{cmd: c, a_num: an, a_den: ad, b_num: bn, b_den: bd};
        pending_ops.push_back(op);
    endtask

    task automatic add_random_ops(input int count);
        logic [2:0] c;
        for (int i = 0; i < count; i++) begin
            c = ($urandom_range(99, 0) < 4) ? 3'($urandom_range(CMD_BAD_HI, CMD_BAD_LO))
                                            : 3'($urandom_range(CMD_CMP, CMD_ADD));
            add_op(c, rand_num(), rand_den(), rand_num(), rand_den());
        end
    endtask

    // wait until the stimulus is sent and every result is back
    task automatic wait_drained();
        @(posedge i_clk);
        #1;
        while (pending_ops.size() != 0 || s_axis_tvalid || expected_fracs.size() != 0) begin
            @(posedge i_clk);
            #1;
        end
    endtask

    // sender: pops pending operands, holds data until the transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_fracs.push_back(predict_frac(cur_ops));
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_ops.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    cur_ops = pending_ops.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, cur_ops.b_den, cur_ops.b_num, cur_ops.a_den,
                                      cur_ops.a_num, cur_ops.cmd};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, long hold on request, checks each transfer
    always @(posedge i_clk) begin
        t_fraction want;
        t_fraction got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.num = m_axis_tdata[63:0];
                got.den = m_axis_tdata[126:64];
                got.lt  = m_axis_tdata[127];
                got.eq  = m_axis_tdata[128];
                got.gt  = m_axis_tdata[129];
                got.st  = m_axis_tdata[130];
                if (expected_fracs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result num=%0d den=%0d",
                                 $signed(got.num), got.den);
                end else begin
                    want = expected_fracs.pop_front();
                    n_checked++;
                    if (want.st)
                        n_errors_seen++;
                    if (want.lt | want.eq | want.gt)
                        n_cmp_seen++;
                    if ((got.num !== want.num) || (got.den !== want.den) ||
                        (got.lt !== want.lt) || (got.eq !== want.eq) ||
                        (got.gt !== want.gt) || (got.st !== want.st)) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch #%0d: exp num=%0d den=%0d lt=%b eq=%b gt=%b",
                                     n_checked, $signed(want.num), want.den, want.lt,
                                     want.eq, want.gt, " st=%b, got num=%0d den=%0d",
                                     want.st, $signed(got.num), got.den,
                                     " lt=%b eq=%b gt=%b st=%b",
                                     got.lt, got.eq, got.gt, got.st);
                    end
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= $urandom_range(99, 0) >= recv_stall_pct;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int idle_set[4][2];
        idle_set = '{'{0, 0}, '{48, 0}, '{0, 48}, '{12, 12}};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        mismatches = 0;
        idle_cycles = 0;
        n_sent = 0;
        n_checked = 0;
        n_errors_seen = 0;
        n_cmp_seen = 0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every command, error and equality cases
        add_op(CMD_ADD, 32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000, 31'd1);
        add_op(CMD_SUB, 32'h7FFF_FFFF, 31'd1, 32'h8000_0000, 31'h7FFF_FFFF);
        add_op(CMD_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
        add_op(CMD_MUL, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        add_op(CMD_DIV, 32'h8000_0000, 31'd3, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        add_op(CMD_DIV, 32'd5, 31'd7, 32'd0, 31'd9);
        add_op(CMD_ADD, 32'd3, 31'd4, -32'sd3, 31'd4);
        add_op(CMD_SUB, -32'sd6, 31'd8, -32'sd3, 31'd4);
        add_op(CMD_MUL, 32'd0, 31'd5, -32'sd7, 31'd3);
        add_op(CMD_CMP, 32'd1, 31'd2, 32'd2, 31'd4);
        add_op(CMD_CMP, -32'sd1, 31'd3, 32'd1, 31'd3);
        add_op(CMD_CMP, 32'h7FFF_FFFF, 31'd1, 32'h8000_0000, 31'd1);
        add_op(CMD_CMP, 32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        add_op(CMD_ADD, 32'd1, 31'd0, 32'd1, 31'd1);
        add_op(CMD_CMP, 32'd1, 31'd1, 32'd1, 31'd0);
        add_op(CMD_BAD_LO, 32'd1, 31'd1, 32'd1, 31'd1);
        add_op(3'd6, 32'd2, 31'd3, 32'd4, 31'd5);
        add_op(CMD_BAD_HI, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        add_op(CMD_DIV, 32'd6, 31'd4, -32'sd9, 31'd2);
        add_op(CMD_ADD, 32'h5555_5555, 31'h2AAA_AAAA, 32'hAAAA_AAAA, 31'h5555_5555);
        wait_drained();

        // random phases with different idle/stall mixes
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_set[p][0];
            recv_stall_pct = idle_set[p][1];
            add_random_ops(383);
            if (p == 0)
                hold_req++;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d transfers in, %0d results checked (%0d error, %0d compare)",
                 n_sent, n_checked, n_errors_seen, n_cmp_seen);
        $display("idle phases: none, sender 48%%, receiver 48%%, both 12%%, plus a long hold");
        if (mismatches == 0 && expected_fracs.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_fracs.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
